FILE: src/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: src/tccdr_pkg.sv
// types and constants of the text cell compositor
// no dependencies
package tccdr_pkg;

	localparam logic [2:0] MODE_PUT_CELL = 3'd0;
	localparam logic [2:0] MODE_PUT_COLL = 3'd1;
	localparam logic [2:0] MODE_MERGE    = 3'd2;
	localparam logic [2:0] MODE_READ     = 3'd3;
	localparam logic [2:0] MODE_DRAW     = 3'd4;
	localparam logic [2:0] MODE_CLEAR    = 3'd5;

	localparam logic [2:0] CFG_WIDTH     = 3'd0;
	localparam logic [2:0] CFG_HEIGHT    = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_X  = 3'd2;
	localparam logic [2:0] CFG_ORIGIN_Y  = 3'd3;
	localparam logic [2:0] CFG_COLOR_KEY = 3'd4;

	localparam logic [7:0] BLANK_CHAR = 8'd32;

	typedef enum logic [2:0] {
		OP_PUT_CELL,
		OP_PUT_COLL,
		OP_MERGE,
		OP_READ,
		OP_DRAW,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             hit;
		logic [7:0]       character;
		logic [7:0]       color;
		logic [15:0]      collision;
		logic [10:0]      row;
	} front_item_t;

	typedef struct packed {
		logic [10:0]        screen_col;
		logic [10:0]        screen_row;
		logic [7:0]         out_character;
		logic [7:0]         out_color;
		logic signed [15:0] out_collision;
		logic               cell_valid;
		logic               last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_MERGE,
		ST_READ,
		ST_DRAW,
		ST_DRAW_END,
		ST_CLEAR
	} back_state_t;

	typedef struct packed {
		logic init_done;
	} back_status_t;

endpackage

FILE: src/tccdr_if.sv
// channel interfaces: input items, result items, configuration writes
// no dependencies
interface tccdr_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [10:0] col;
	logic signed [10:0] row;
	logic [7:0]         character;
	logic [7:0]         color;
	logic signed [15:0] collision;
	logic [7:0]         source_key;
	modport source (output valid, mode, col, row, character, color, collision, source_key,
		input ready);
	modport sink (input valid, mode, col, row, character, color, collision, source_key,
		output ready);
endinterface

interface tccdr_out_if;
	logic               valid;
	logic               ready;
	logic [10:0]        screen_col;
	logic [10:0]        screen_row;
	logic [7:0]         out_character;
	logic [7:0]         out_color;
	logic signed [15:0] out_collision;
	logic               cell_valid;
	logic               last;
	modport source (output valid, screen_col, screen_row, out_character, out_color,
		out_collision, cell_valid, last, input ready);
	modport sink (input valid, screen_col, screen_row, out_character, out_color,
		out_collision, cell_valid, last, output ready);
endinterface

interface tccdr_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [9:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/tccdr_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module tccdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/tccdr_front.sv
// front part: accepts input transactions, classifies them, queues the useful ones
// depends on tccdr_pkg and tccdr_if
module tccdr_front #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tccdr_in_if.sink                     src,
	input  logic [$clog2(MAX_COLS+1)-1:0] eff_w,
	input  logic [$clog2(MAX_ROWS+1)-1:0] eff_h,
	input  tccdr_pkg::back_status_t      status,
	output logic                         q_valid,
	output tccdr_pkg::front_item_t       q_item,
	output logic [(MAX_COLS*MAX_ROWS>1?$clog2(MAX_COLS*MAX_ROWS):1)-1:0] q_addr,
	input  logic                         q_pop
);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CBITS = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int RBITS = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

	tccdr_pkg::front_item_t item_q [2];
	logic [AW-1:0]          addr_q [2];
	logic                   wp_q, rp_q;
	logic [1:0]             cnt_q;

	logic                   col_ok, row_ok, keep, push;
	tccdr_pkg::front_item_t item;
	logic [AW-1:0]          addr;
	logic [CBITS-1:0]       col_lo;
	logic [RBITS-1:0]       row_lo;

	assign col_ok = !src.col[10] && ($unsigned(src.col) < 11'(eff_w));
	assign row_ok = !src.row[10] && ($unsigned(src.row) < 11'(eff_h));
	assign col_lo = src.col[CBITS-1:0];
	assign row_lo = src.row[RBITS-1:0];

	always_comb begin
		item.op        = tccdr_pkg::OP_PUT_CELL;
		item.hit       = col_ok && row_ok;
		item.character = src.character;
		item.color     = src.color;
		item.collision = src.collision;
		item.row       = src.row;
		addr           = AW'(row_lo) * AW'(MAX_COLS) + AW'(col_lo);
		keep           = 1'b0;
		case (src.mode)
			tccdr_pkg::MODE_PUT_CELL: begin
				item.op = tccdr_pkg::OP_PUT_CELL;
				keep    = col_ok && row_ok;
			end
			tccdr_pkg::MODE_PUT_COLL: begin
				item.op = tccdr_pkg::OP_PUT_COLL;
				keep    = col_ok && row_ok;
			end
			tccdr_pkg::MODE_MERGE: begin
				item.op = tccdr_pkg::OP_MERGE;
				keep    = col_ok && row_ok && (src.color != src.source_key);
			end
			tccdr_pkg::MODE_READ: begin
				item.op = tccdr_pkg::OP_READ;
				keep    = 1'b1;
			end
			tccdr_pkg::MODE_DRAW: begin
				item.op  = tccdr_pkg::OP_DRAW;
				item.hit = row_ok;
				addr     = AW'(row_lo) * AW'(MAX_COLS);
				keep     = 1'b1;
			end
			tccdr_pkg::MODE_CLEAR: begin
				item.op = tccdr_pkg::OP_CLEAR;
				keep    = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign src.ready = status.init_done && (cnt_q != 2'd2);
	assign push      = src.valid && src.ready && keep;
	assign q_valid   = cnt_q != 2'd0;
	assign q_item    = item_q[rp_q];
	assign q_addr    = addr_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wp_q] <= item;
			addr_q[wp_q] <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

FILE: src/tccdr_back.sv
// back part: runs queued operations on the cell stores and drives the result channel
// depends on tccdr_pkg, tccdr_if and tccdr_ram
module tccdr_back #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(MAX_COLS+1)-1:0] eff_w,
	input  logic [$clog2(MAX_ROWS+1)-1:0] eff_h,
	input  logic [9:0]                   origin_x,
	input  logic [9:0]                   origin_y,
	input  logic [7:0]                   color_key,
	input  logic                         q_valid,
	input  tccdr_pkg::front_item_t       q_item,
	input  logic [(MAX_COLS*MAX_ROWS>1?$clog2(MAX_COLS*MAX_ROWS):1)-1:0] q_addr,
	output logic                         q_pop,
	output tccdr_pkg::back_status_t      status,
	tccdr_out_if.source                  res
);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CBITS = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int RBITS = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

	tccdr_pkg::back_state_t state_q, state_d;
	tccdr_pkg::front_item_t item_q;
	logic [AW-1:0]          addr_q, init_q;
	logic [CBITS-1:0]       x_q;
	logic [RBITS-1:0]       y_q;
	logic                   pend_v_q, out_v_q;
	tccdr_pkg::out_item_t   pend_q, out_q;

	logic                   fcc_we, coll_we, back_we;
	logic [AW-1:0]          fcc_waddr, coll_waddr, back_waddr, raddr;
	logic [15:0]            fcc_wdata, coll_wdata, back_wdata;
	logic [15:0]            fcc_rd, coll_rd, back_rd;

	logic                   can_push, push_v, pend_load, pend_clr, start;
	tccdr_pkg::out_item_t   push_d, new_cell;
	logic                   emit, stall, adv, x_last, y_last, clr_last;
	logic [AW-1:0]          draw_addr, clr_addr;

	tccdr_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_front_cc (
		.clk(clk), .we(fcc_we), .waddr(fcc_waddr), .wdata(fcc_wdata),
		.raddr(raddr), .rdata(fcc_rd)
	);
	tccdr_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_front_coll (
		.clk(clk), .we(coll_we), .waddr(coll_waddr), .wdata(coll_wdata),
		.raddr(raddr), .rdata(coll_rd)
	);
	tccdr_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_back_cc (
		.clk(clk), .we(back_we), .waddr(back_waddr), .wdata(back_wdata),
		.raddr(raddr), .rdata(back_rd)
	);

	assign can_push  = !out_v_q || res.ready;
	assign emit      = (11'(x_q) < 11'(eff_w)) && (fcc_rd != back_rd)
		&& (fcc_rd[7:0] != color_key);
	assign stall     = emit && pend_v_q && !can_push;
	assign adv       = !stall;
	assign x_last    = x_q == CBITS'(MAX_COLS - 1);
	assign draw_addr = addr_q + AW'(x_q);
	assign clr_addr  = AW'(y_q) * AW'(MAX_COLS) + AW'(x_q);
	assign clr_last  = (x_q == CBITS'(eff_w - 1'b1)) && y_last;
	assign y_last    = y_q == RBITS'(eff_h - 1'b1);

	always_comb begin
		new_cell.screen_col    = 11'(x_q) + {1'b0, origin_x};
		new_cell.screen_row    = item_q.row + {1'b0, origin_y};
		new_cell.out_character = fcc_rd[15:8];
		new_cell.out_color     = fcc_rd[7:0];
		new_cell.out_collision = '0;
		new_cell.cell_valid    = 1'b1;
		new_cell.last          = 1'b0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tccdr_pkg::ST_INIT: begin
				if (init_q == AW'(DEPTH - 1)) begin
					state_d = tccdr_pkg::ST_IDLE;
				end
			end
			tccdr_pkg::ST_IDLE: begin
				if (q_valid) begin
					case (q_item.op)
						tccdr_pkg::OP_MERGE: state_d = tccdr_pkg::ST_MERGE;
						tccdr_pkg::OP_READ:  state_d = tccdr_pkg::ST_READ;
						tccdr_pkg::OP_DRAW:  state_d = q_item.hit ? tccdr_pkg::ST_DRAW
							: tccdr_pkg::ST_DRAW_END;
						tccdr_pkg::OP_CLEAR: begin
							if (eff_w != '0 && eff_h != '0) begin
								state_d = tccdr_pkg::ST_CLEAR;
							end
						end
						default: state_d = tccdr_pkg::ST_IDLE;
					endcase
				end
			end
			tccdr_pkg::ST_MERGE: state_d = tccdr_pkg::ST_IDLE;
			tccdr_pkg::ST_READ: begin
				if (can_push) begin
					state_d = tccdr_pkg::ST_IDLE;
				end
			end
			tccdr_pkg::ST_DRAW: begin
				if (adv && x_last) begin
					state_d = tccdr_pkg::ST_DRAW_END;
				end
			end
			tccdr_pkg::ST_DRAW_END: begin
				if (can_push) begin
					state_d = tccdr_pkg::ST_IDLE;
				end
			end
			tccdr_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = tccdr_pkg::ST_IDLE;
				end
			end
			default: state_d = tccdr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		fcc_we     = 1'b0;
		coll_we    = 1'b0;
		back_we    = 1'b0;
		fcc_waddr  = q_addr;
		coll_waddr = q_addr;
		back_waddr = draw_addr;
		fcc_wdata  = {q_item.character, q_item.color};
		coll_wdata = q_item.collision;
		back_wdata = fcc_rd;
		raddr      = q_addr;
		q_pop      = 1'b0;
		start      = 1'b0;
		push_v     = 1'b0;
		push_d     = pend_q;
		pend_load  = 1'b0;
		pend_clr   = 1'b0;
		case (state_q)
			tccdr_pkg::ST_INIT: begin
				fcc_we     = 1'b1;
				coll_we    = 1'b1;
				back_we    = 1'b1;
				fcc_waddr  = init_q;
				coll_waddr = init_q;
				back_waddr = init_q;
				fcc_wdata  = '0;
				coll_wdata = '0;
				back_wdata = '0;
			end
			tccdr_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					start   = 1'b1;
					fcc_we  = q_item.op == tccdr_pkg::OP_PUT_CELL;
					coll_we = q_item.op == tccdr_pkg::OP_PUT_COLL;
				end
			end
			tccdr_pkg::ST_MERGE: begin
				raddr      = addr_q;
				fcc_waddr  = addr_q;
				coll_waddr = addr_q;
				fcc_wdata  = {item_q.character, item_q.color};
				coll_wdata = item_q.collision;
				if (fcc_rd != {item_q.character, item_q.color}
						|| coll_rd != item_q.collision) begin
					fcc_we  = 1'b1;
					coll_we = 1'b1;
				end
			end
			tccdr_pkg::ST_READ: begin
				raddr                = addr_q;
				push_v               = can_push;
				push_d               = '0;
				push_d.out_collision = item_q.hit ? coll_rd : '0;
				push_d.cell_valid    = 1'b1;
				push_d.last          = 1'b1;
			end
			tccdr_pkg::ST_DRAW: begin
				raddr   = adv ? draw_addr + AW'(1) : draw_addr;
				back_we = adv;
				if (adv && emit) begin
					pend_load = 1'b1;
					push_v    = pend_v_q;
				end
			end
			tccdr_pkg::ST_DRAW_END: begin
				push_v = can_push;
				if (pend_v_q) begin
					push_d.last = 1'b1;
				end else begin
					push_d      = '0;
					push_d.last = 1'b1;
				end
				pend_clr = can_push;
			end
			tccdr_pkg::ST_CLEAR: begin
				fcc_we     = 1'b1;
				coll_we    = 1'b1;
				fcc_waddr  = clr_addr;
				coll_waddr = clr_addr;
				fcc_wdata  = {tccdr_pkg::BLANK_CHAR, 8'd0};
				coll_wdata = '0;
			end
			default: begin
				fcc_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= q_item;
			addr_q <= q_addr;
		end
		if (pend_load) begin
			pend_q <= new_cell;
		end
		if (push_v) begin
			out_q <= push_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tccdr_pkg::ST_INIT;
			init_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tccdr_pkg::ST_INIT) begin
				init_q <= init_q + AW'(1);
			end
			if (start) begin
				x_q <= '0;
				y_q <= '0;
			end else if (state_q == tccdr_pkg::ST_DRAW && adv) begin
				x_q <= x_q + CBITS'(1);
			end else if (state_q == tccdr_pkg::ST_CLEAR) begin
				if (x_q == CBITS'(eff_w - 1'b1)) begin
					x_q <= '0;
					y_q <= y_q + RBITS'(1);
				end else begin
					x_q <= x_q + CBITS'(1);
				end
			end
			if (pend_load) begin
				pend_v_q <= 1'b1;
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
			if (can_push) begin
				out_v_q <= push_v;
			end
		end
	end

	assign status.init_done = state_q != tccdr_pkg::ST_INIT;

	assign res.valid         = out_v_q;
	assign res.screen_col    = out_q.screen_col;
	assign res.screen_row    = out_q.screen_row;
	assign res.out_character = out_q.out_character;
	assign res.out_color     = out_q.out_color;
	assign res.out_collision = out_q.out_collision;
	assign res.cell_valid    = out_q.cell_valid;
	assign res.last          = out_q.last;
endmodule

FILE: src/text_cell_compositor_dirty_refresh.sv
// top level: configuration registers, front classifier and back executor
// put, merge, read, row draw and clear run one at a time in the back sequencer over the
// simple dual port cell rams; the front queue holds up to two pending items meanwhile
// after reset a sweep zeroes all MAX_COLS*MAX_ROWS cells of the stores, input held off
// configuration registers reset to zero and are writable at all times
// depends on tccdr_pkg, tccdr_if, tccdr_front, tccdr_back, assert_macros.svh
`include "assert_macros.svh"
module text_cell_compositor_dirty_refresh #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	tccdr_in_if.sink     src,
	tccdr_out_if.source  res,
	tccdr_cfg_if.sink    cfg
);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int EWW   = $clog2(MAX_COLS + 1);
	localparam int EHW   = $clog2(MAX_ROWS + 1);

	logic [6:0] width_q, height_q;
	logic [9:0] origin_x_q, origin_y_q;
	logic [7:0] color_key_q;
	logic [EWW-1:0] eff_w;
	logic [EHW-1:0] eff_h;

	tccdr_pkg::back_status_t status;
	tccdr_pkg::front_item_t  q_item;
	logic                    q_valid, q_pop;
	logic [AW-1:0]           q_addr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= '0;
			height_q    <= '0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			color_key_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				tccdr_pkg::CFG_WIDTH:     width_q     <= cfg.data[6:0];
				tccdr_pkg::CFG_HEIGHT:    height_q    <= cfg.data[6:0];
				tccdr_pkg::CFG_ORIGIN_X:  origin_x_q  <= cfg.data;
				tccdr_pkg::CFG_ORIGIN_Y:  origin_y_q  <= cfg.data;
				tccdr_pkg::CFG_COLOR_KEY: color_key_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	assign eff_w = (11'(width_q) > 11'(MAX_COLS)) ? EWW'(MAX_COLS) : EWW'(width_q);
	assign eff_h = (11'(height_q) > 11'(MAX_ROWS)) ? EHW'(MAX_ROWS) : EHW'(height_q);

	tccdr_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
		.clk(clk), .arst_n(arst_n), .src(src), .eff_w(eff_w), .eff_h(eff_h),
		.status(status), .q_valid(q_valid), .q_item(q_item), .q_addr(q_addr),
		.q_pop(q_pop)
	);

	tccdr_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk(clk), .arst_n(arst_n), .eff_w(eff_w), .eff_h(eff_h),
		.origin_x(origin_x_q), .origin_y(origin_y_q), .color_key(color_key_q),
		.q_valid(q_valid), .q_item(q_item), .q_addr(q_addr), .q_pop(q_pop),
		.status(status), .res(res)
	);

	// no transaction accepted or produced while the stores are being zeroed
	`ASSERT_IMPLIES(a_no_accept_init, clk, arst_n, !status.init_done, !src.ready)
	`ASSERT_IMPLIES(a_no_result_init, clk, arst_n, !status.init_done, !res.valid)
	`ASSERT_NEXT(a_init_stays_done, clk, arst_n, status.init_done, status.init_done)
endmodule
